@@ src/ssrm_pkg.sv @@
// ssrm_pkg: shared field widths, operation codes and types of the sliding rate meter
// no dependencies; used by sliding_second_rate_meter_core
package ssrm_pkg;

    localparam int TIME_W   = 32;
    localparam int STREAM_W = 6;
    localparam int COUNT_W  = 16;
    localparam int WLEN_W   = 4;
    localparam int SUM_W    = 32;
    localparam int FRAC_W   = 8;
    localparam int RATE_W   = SUM_W + FRAC_W;
    localparam int DIVC_W   = $clog2(RATE_W);
    localparam int ALU_W    = SUM_W + 1;

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic [TIME_W-1:0] t_time;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [RATE_W-1:0] t_rate;

    // operands of the shared add/subtract unit
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

endpackage

@@ src/ssrm_ram.sv @@
// ssrm_ram: generic single write port, single read port ram with registered read
// no dependencies; used for bucket stamps and stream counters
module ssrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/sliding_second_rate_meter_core.sv @@
// sliding_second_rate_meter_core: ring of one-second buckets with per-stream counters
// depends on ssrm_pkg and ssrm_ram
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+----------------------------------------------
//  request | in        | i_valid, o_stall | i_operation i_time_now i_stream i_event_count
//          |           |                  | i_window_len
//  result  | out       | o_valid, i_stall | o_window_sum o_rate_q8 o_valid_res
//
// an add or a query first opens the next bucket when the time passes the current stamp, and
// walks on, clearing the stale buckets that follow it; a query then sums the n buckets of its
// window, n being the window length, and divides; the walk uses the single time ram port and
// the divider makes one quotient bit per cycle in the shared add/subtract unit
// after reset the counter ram is swept with o_stall high
// one transaction is worked at a time; the next is taken while a result waits in the
// output register, and a finished result waits there for i_stall to drop
module sliding_second_rate_meter_core #(
    parameter int BUCKETS = 16,
    parameter int STREAMS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_operation,
    input  logic [ssrm_pkg::TIME_W-1:0]   i_time_now,
    input  logic [ssrm_pkg::STREAM_W-1:0] i_stream,
    input  logic [ssrm_pkg::COUNT_W-1:0]  i_event_count,
    input  logic [ssrm_pkg::WLEN_W-1:0]   i_window_len,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ssrm_pkg::SUM_W-1:0]    o_window_sum,
    output logic [ssrm_pkg::RATE_W-1:0]   o_rate_q8,
    output logic                          o_valid_res
);

    localparam int BW        = $clog2(BUCKETS);
    localparam int SW        = (STREAMS > 1) ? $clog2(STREAMS) : 1;
    localparam int CAW       = BW + SW;
    localparam int CNT_DEPTH = BUCKETS << SW;
    localparam int ALU_W     = ssrm_pkg::ALU_W;
    localparam int SUM_W     = ssrm_pkg::SUM_W;
    localparam int RATE_W    = ssrm_pkg::RATE_W;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADV      = 4'd2;
    localparam logic [3:0] S_WALK_RD  = 4'd3;
    localparam logic [3:0] S_WALK_CMP = 4'd4;
    localparam logic [3:0] S_OPER     = 4'd5;
    localparam logic [3:0] S_ADD_WR   = 4'd6;
    localparam logic [3:0] S_SUM_RD   = 4'd7;
    localparam logic [3:0] S_SUM_ACC  = 4'd8;
    localparam logic [3:0] S_DIV      = 4'd9;
    localparam logic [3:0] S_DONE     = 4'd10;

    logic [3:0]                   r_state, n_state;
    logic [CAW-1:0]               r_clr, n_clr;
    logic                         r_op, n_op;
    ssrm_pkg::t_time              r_time, n_time;
    logic [SW-1:0]                r_sidx, n_sidx;
    logic                         r_svalid, n_svalid;
    logic [ssrm_pkg::COUNT_W-1:0] r_cnt, n_cnt;
    logic [BW-1:0]                r_n, n_n;
    logic [BW-1:0]                r_cur, n_cur;
    ssrm_pkg::t_time              r_cur_time, n_cur_time;
    logic [BW-1:0]                r_walk, n_walk;
    logic [BW-1:0]                r_step, n_step;
    ssrm_pkg::t_sum               r_sum, n_sum;
    logic [BW-1:0]                r_rem, n_rem;
    ssrm_pkg::t_rate              r_div, n_div;
    logic [ssrm_pkg::DIVC_W-1:0]  r_dcnt, n_dcnt;
    logic                         r_o_valid, n_o_valid;
    ssrm_pkg::t_sum               r_o_sum, n_o_sum;
    ssrm_pkg::t_rate              r_o_rate, n_o_rate;
    logic                         r_o_vres, n_o_vres;

    // ram ports
    logic                 tm_we;
    logic [BW-1:0]        tm_waddr, tm_raddr;
    ssrm_pkg::t_time      tm_wdata, tm_rdata;
    logic                 cnt_we;
    logic [CAW-1:0]       cnt_waddr, cnt_raddr;
    logic [2*SUM_W-1:0]   cnt_wdata, cnt_rdata;

    // shared add/subtract unit
    ssrm_pkg::t_alu_req   alu;
    logic [ALU_W:0]       alu_res;
    logic                 alu_carry;

    logic                 accept;
    logic [BW-1:0]        cur_inc, walk_inc, win_start;
    logic [BW:0]          win_diff;
    logic [BW-1:0]        wlen_sel;
    logic [31:0]          walk_limit;
    logic                 entry_hit;
    ssrm_pkg::t_sum       entry_cnt;
    logic [BW:0]          div_shift;

    ssrm_ram #(
        .WIDTH(ssrm_pkg::TIME_W),
        .DEPTH(BUCKETS)
    ) u_time_ram (
        .i_clk  (i_clk),
        .i_we   (tm_we),
        .i_waddr(tm_waddr),
        .i_wdata(tm_wdata),
        .i_raddr(tm_raddr),
        .o_rdata(tm_rdata)
    );

    // entry = {bucket stamp when written, count}
    ssrm_ram #(
        .WIDTH(2 * SUM_W),
        .DEPTH(CNT_DEPTH)
    ) u_count_ram (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr),
        .o_rdata(cnt_rdata)
    );

    assign alu_res   = {1'b0, alu.a} + {1'b0, (alu.sub ? ~alu.b : alu.b)}
                       + (ALU_W + 1)'(alu.sub);
    assign alu_carry = alu_res[ALU_W];

    assign accept = i_valid && !o_stall;

    assign cur_inc  = (r_cur == BW'(BUCKETS - 1)) ? '0 : r_cur + BW'(1);
    assign walk_inc = (r_walk == BW'(BUCKETS - 1)) ? '0 : r_walk + BW'(1);

    assign win_diff  = {1'b0, r_cur} - {1'b0, r_n};
    assign win_start = win_diff[BW] ? BW'(win_diff + (BW + 1)'(BUCKETS)) : win_diff[BW-1:0];

    assign wlen_sel = (i_window_len == '0 || 32'(i_window_len) > 32'(BUCKETS - 1))
                      ? BW'(BUCKETS - 1) : BW'(i_window_len);

    assign walk_limit = (r_op == ssrm_pkg::OP_ADD) ? 32'(BUCKETS) : 32'(BUCKETS + 1);

    // a counter entry counts only if it was written under the bucket's present stamp
    assign entry_hit = (r_state == S_ADD_WR) ? (cnt_rdata[2*SUM_W-1:SUM_W] == r_cur_time)
                                             : (cnt_rdata[2*SUM_W-1:SUM_W] == tm_rdata);
    assign entry_cnt = entry_hit ? cnt_rdata[SUM_W-1:0] : '0;

    assign div_shift = {r_rem, r_div[RATE_W-1]};

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_op       = r_op;
        n_time     = r_time;
        n_sidx     = r_sidx;
        n_svalid   = r_svalid;
        n_cnt      = r_cnt;
        n_n        = r_n;
        n_cur      = r_cur;
        n_cur_time = r_cur_time;
        n_walk     = r_walk;
        n_step     = r_step;
        n_sum      = r_sum;
        n_rem      = r_rem;
        n_div      = r_div;
        n_dcnt     = r_dcnt;
        n_o_valid  = r_o_valid;
        n_o_sum    = r_o_sum;
        n_o_rate   = r_o_rate;
        n_o_vres   = r_o_vres;

        tm_we     = 1'b0;
        tm_waddr  = r_walk;
        tm_wdata  = r_time;
        tm_raddr  = r_walk;
        cnt_we    = 1'b0;
        cnt_waddr = {r_cur, r_sidx};
        cnt_wdata = '0;
        cnt_raddr = {r_walk, r_sidx};

        alu.a   = {1'b0, r_time};
        alu.b   = {1'b0, r_cur_time};
        alu.sub = 1'b1;

        if (r_o_valid && !i_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                tm_we     = (r_clr[SW-1:0] == '0);
                tm_waddr  = r_clr[CAW-1:SW];
                tm_wdata  = '0;
                n_clr     = r_clr + CAW'(1);
                if (r_clr == CAW'(CNT_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_op     = i_operation;
                    n_time   = i_time_now;
                    n_sidx   = SW'(i_stream);
                    n_svalid = ({1'b0, i_stream} < 7'(STREAMS));
                    n_cnt    = i_event_count;
                    n_n      = wlen_sel;
                    n_state  = S_ADV;
                end
            end
            S_ADV: begin
                // time strictly past the current bucket opens the next one
                if (alu_carry && alu_res[31:0] != '0) begin
                    tm_we      = 1'b1;
                    tm_waddr   = cur_inc;
                    n_cur      = cur_inc;
                    n_cur_time = r_time;
                    n_walk     = cur_inc;
                    n_step     = BW'(BUCKETS - 1);
                    n_state    = S_WALK_RD;
                end else begin
                    n_state = S_OPER;
                end
            end
            S_WALK_RD: begin
                if (r_step == '0) begin
                    n_state = S_OPER;
                end else begin
                    tm_raddr = walk_inc;
                    n_walk   = walk_inc;
                    n_step   = r_step - BW'(1);
                    n_state  = S_WALK_CMP;
                end
            end
            S_WALK_CMP: begin
                alu.b = {1'b0, tm_rdata};
                if (alu_carry && alu_res[31:0] >= walk_limit) begin
                    tm_we      = 1'b1;
                    tm_waddr   = r_walk;
                    n_cur      = r_walk;
                    n_cur_time = r_time;
                    n_state    = S_WALK_RD;
                end else begin
                    n_state = S_OPER;
                end
            end
            S_OPER: begin
                n_sum = '0;
                n_div = '0;
                if (!r_svalid) begin
                    n_state = S_DONE;
                end else if (r_op == ssrm_pkg::OP_ADD) begin
                    cnt_raddr = {r_cur, r_sidx};
                    n_state   = S_ADD_WR;
                end else begin
                    n_walk  = win_start;
                    n_step  = r_n;
                    n_state = S_SUM_RD;
                end
            end
            S_ADD_WR: begin
                alu.a     = {1'b0, entry_cnt};
                alu.b     = ALU_W'(r_cnt);
                alu.sub   = 1'b0;
                cnt_we    = 1'b1;
                cnt_waddr = {r_cur, r_sidx};
                cnt_wdata = {r_cur_time, (alu_res[SUM_W] ? {SUM_W{1'b1}} : alu_res[SUM_W-1:0])};
                n_state   = S_DONE;
            end
            S_SUM_RD: begin
                if (r_step == '0) begin
                    n_rem   = '0;
                    n_div   = {r_sum, {ssrm_pkg::FRAC_W{1'b0}}};
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end else begin
                    tm_raddr  = r_walk;
                    cnt_raddr = {r_walk, r_sidx};
                    n_walk    = walk_inc;
                    n_step    = r_step - BW'(1);
                    n_state   = S_SUM_ACC;
                end
            end
            S_SUM_ACC: begin
                alu.a   = {1'b0, r_sum};
                alu.b   = {1'b0, entry_cnt};
                alu.sub = 1'b0;
                n_sum   = alu_res[SUM_W] ? {SUM_W{1'b1}} : alu_res[SUM_W-1:0];
                n_state = S_SUM_RD;
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                alu.a  = ALU_W'(div_shift);
                alu.b  = ALU_W'(r_n);
                n_rem  = alu_carry ? alu_res[BW-1:0] : div_shift[BW-1:0];
                n_div  = {r_div[RATE_W-2:0], alu_carry};
                n_dcnt = r_dcnt + ssrm_pkg::DIVC_W'(1);
                if (r_dcnt == ssrm_pkg::DIVC_W'(RATE_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_o_sum   = r_sum;
                    n_o_rate  = r_div;
                    n_o_vres  = r_svalid;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_cur      <= '0;
            r_cur_time <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_cur      <= n_cur;
            r_cur_time <= n_cur_time;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_time   <= n_time;
        r_sidx   <= n_sidx;
        r_svalid <= n_svalid;
        r_cnt    <= n_cnt;
        r_n      <= n_n;
        r_walk   <= n_walk;
        r_step   <= n_step;
        r_sum    <= n_sum;
        r_rem    <= n_rem;
        r_div    <= n_div;
        r_dcnt   <= n_dcnt;
        r_o_sum  <= n_o_sum;
        r_o_rate <= n_o_rate;
        r_o_vres <= n_o_vres;
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_window_sum = r_o_sum;
    assign o_rate_q8    = r_o_rate;
    assign o_valid_res  = r_o_vres;

    // divider remainder must stay below the window length
    a_rem_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_n))
        else $error("divider remainder not below window length");

    // a waiting result is never dropped while the sink stalls
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && i_stall) |=> r_o_valid)
        else $error("stalled result lost");

    // stamp of the current bucket never moves backwards
    a_time_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cur_time >= $past(r_cur_time)))
        else $error("current bucket stamp decreased");

    // the walk never revisits the bucket just made current
    a_walk_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK_CMP) |-> (r_walk != r_cur))
        else $error("walk reached the current bucket");

    // a valid query always averages over at least one bucket
    a_window_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM_RD) |-> (r_n != '0))
        else $error("empty query window");

endmodule

@@ dv/sliding_second_rate_meter_core_tb.sv @@
`timescale 1ns / 100ps
// sliding_second_rate_meter_core_tb: self-checking testbench of the sliding one-second rate meter
// directed and random transactions, results predicted in the bench and compared field by field
// depends on ssrm_pkg and sliding_second_rate_meter_core
module sliding_second_rate_meter_core_tb;

    localparam int NB           = 16;
    localparam int NS           = 32;
    localparam int RANDOM_ITEMS = 1450;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 150;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        ssrm_pkg::t_sum  window_sum;
        ssrm_pkg::t_rate rate_q8;
        logic            valid_res;
    } t_meter_reply;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_valid       = 1'b0;
    logic                          i_operation   = ssrm_pkg::OP_ADD;
    logic [ssrm_pkg::TIME_W-1:0]   i_time_now    = '0;
    logic [ssrm_pkg::STREAM_W-1:0] i_stream      = '0;
    logic [ssrm_pkg::COUNT_W-1:0]  i_event_count = '0;
    logic [ssrm_pkg::WLEN_W-1:0]   i_window_len  = '0;
    logic                          i_stall       = 1'b0;
    logic                          o_stall;
    logic                          o_valid;
    logic [ssrm_pkg::SUM_W-1:0]    o_window_sum;
    logic [ssrm_pkg::RATE_W-1:0]   o_rate_q8;
    logic                          o_valid_res;

    // bench copy of the ring
    ssrm_pkg::t_time stamp_of [NB];
    ssrm_pkg::t_sum  tally_of [NB][NS];
    int              head_bucket;

    t_meter_reply expected_replies [$];
    int           mismatch_count = 0;
    int           idle_cycles    = 0;
    int           rx_hold        = 0;
    bit           steady         = 1'b0;

    sliding_second_rate_meter_core #(
        .BUCKETS(NB),
        .STREAMS(NS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_time_now   (i_time_now),
        .i_stream     (i_stream),
        .i_event_count(i_event_count),
        .i_window_len (i_window_len),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_window_sum (o_window_sum),
        .o_rate_q8    (o_rate_q8),
        .o_valid_res  (o_valid_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint age_at(int b, ssrm_pkg::t_time t);
        return longint'(t) - longint'(stamp_of[b]);
    endfunction

    function automatic void wipe_bucket(int b, ssrm_pkg::t_time t);
        for (int k = 0; k < NS; k++) tally_of[b][k] = '0;
        stamp_of[b] = t;
    endfunction

    // advances the ring, applies the add or sums the window, returns the expected reply
    function automatic t_meter_reply predict_meter_reply(logic op, ssrm_pkg::t_time t,
            logic [ssrm_pkg::STREAM_W-1:0] s, logic [ssrm_pkg::COUNT_W-1:0] cnt,
            logic [ssrm_pkg::WLEN_W-1:0] wl);
        t_meter_reply r;
        longint       stale_age;
        logic [63:0]  acc;
        int           walk;
        int           n;
        int           b;
        bit           walking;
        bit           ok;
        stale_age = (op == ssrm_pkg::OP_ADD) ? NB : NB + 1;
        ok        = (s < NS);
        acc       = '0;
        r         = '0;
        if (age_at(head_bucket, t) >= 1) begin
            head_bucket = (head_bucket + 1) % NB;
            wipe_bucket(head_bucket, t);
            walk    = head_bucket;
            walking = 1'b1;
            for (int i = 0; i < NB - 1 && walking; i++) begin
                walk = (walk + 1) % NB;
                if (age_at(walk, t) >= stale_age) begin
                    head_bucket = walk;
                    wipe_bucket(walk, t);
                end else begin
                    walking = 1'b0;
                end
            end
        end
        if (ok && op == ssrm_pkg::OP_ADD) begin
            acc = 64'(tally_of[head_bucket][s]) + 64'(cnt);
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
            tally_of[head_bucket][s] = acc[31:0];
        end else if (ok) begin
            n = (wl == 0 || wl > NB - 1) ? NB - 1 : int'(wl);
            b = (head_bucket + NB - n) % NB;
            for (int i = 0; i < n; i++) begin
                acc += 64'(tally_of[b][s]);
                if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
                b = (b + 1) % NB;
            end
            r.window_sum = acc[31:0];
            r.rate_q8    = ssrm_pkg::t_rate'((acc << ssrm_pkg::FRAC_W) / 64'(n));
        end
        r.valid_res = ok;
        return r;
    endfunction

    // one request transaction; valid stays high across back-to-back requests
    task automatic send_meter_request(logic op, ssrm_pkg::t_time t,
            logic [ssrm_pkg::STREAM_W-1:0] s, logic [ssrm_pkg::COUNT_W-1:0] cnt,
            logic [ssrm_pkg::WLEN_W-1:0] wl);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_operation   <= op;
        i_time_now    <= t;
        i_stream      <= s;
        i_event_count <= cnt;
        i_window_len  <= wl;
        do @(posedge i_clk); while (o_stall);
        expected_replies.push_back(predict_meter_reply(op, t, s, cnt, wl));
    endtask

    task automatic test_add_and_query();
        send_meter_request(ssrm_pkg::OP_ADD, 1, 0, 16'hFFFF, 0);
        send_meter_request(ssrm_pkg::OP_ADD, 1, NS - 1, 1, 4'hF);
        send_meter_request(ssrm_pkg::OP_ADD, 1, 2, 0, 7);
        send_meter_request(ssrm_pkg::OP_QUERY, 2, 0, 0, 1);
        send_meter_request(ssrm_pkg::OP_QUERY, 2, NS - 1, 16'hFFFF, 0);
    endtask

    task automatic test_invalid_stream();
        send_meter_request(ssrm_pkg::OP_ADD, 2, NS, 5, 0);
        send_meter_request(ssrm_pkg::OP_ADD, 3, 63, 16'hFFFF, 0);
        send_meter_request(ssrm_pkg::OP_QUERY, 3, 63, 0, 3);
        send_meter_request(ssrm_pkg::OP_QUERY, 4, NS, 0, 15);
    endtask

    task automatic test_window_lengths();
        send_meter_request(ssrm_pkg::OP_QUERY, 4, 0, 0, 15);
        send_meter_request(ssrm_pkg::OP_QUERY, 4, 0, 0, 2);
        send_meter_request(ssrm_pkg::OP_QUERY, 4, 0, 0, 8);
    endtask

    task automatic test_time_backwards();
        // behind the current bucket, then equal to it: no advance either time
        send_meter_request(ssrm_pkg::OP_ADD, 2, 0, 7, 0);
        send_meter_request(ssrm_pkg::OP_QUERY, 4, 0, 0, 1);
    endtask

    task automatic test_stale_walk();
        send_meter_request(ssrm_pkg::OP_ADD, 20, 1, 100, 0);
        send_meter_request(ssrm_pkg::OP_QUERY, 21, 1, 0, 1);
        send_meter_request(ssrm_pkg::OP_ADD, 37, 1, 3, 0);
        send_meter_request(ssrm_pkg::OP_QUERY, 38, 1, 0, 0);
        send_meter_request(ssrm_pkg::OP_QUERY, 5000, 1, 0, 0);
    endtask

    task automatic test_random_traffic();
        ssrm_pkg::t_time               t_now;
        ssrm_pkg::t_time               t_item;
        logic                          op;
        logic [ssrm_pkg::STREAM_W-1:0] s;
        logic [ssrm_pkg::COUNT_W-1:0]  cnt;
        int                            pick;
        t_now = 32'h8000_0000 | ssrm_pkg::t_time'($urandom_range(0, 32'h3FFF_FFFF));
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 99);
            t_item = t_now;
            if (pick < 45) begin
                t_item = t_now;
            end else if (pick < 75) begin
                t_now  += 1;
                t_item = t_now;
            end else if (pick < 85) begin
                t_now  += $urandom_range(2, 5);
                t_item = t_now;
            end else if (pick < 92) begin
                // one late transaction, the clock itself does not go back
                t_item = t_now - $urandom_range(1, 40);
            end else if (pick < 98) begin
                t_now  += $urandom_range(NB - 2, NB + 3);
                t_item = t_now;
            end else begin
                t_now  += $urandom_range(40, 1 << 20);
                t_item = t_now;
            end
            op   = ($urandom_range(0, 99) < 60) ? ssrm_pkg::OP_ADD : ssrm_pkg::OP_QUERY;
            pick = $urandom_range(0, 99);
            if (pick < 50)      s = ssrm_pkg::STREAM_W'($urandom_range(0, 3));
            else if (pick < 90) s = ssrm_pkg::STREAM_W'($urandom_range(0, NS - 1));
            else                s = ssrm_pkg::STREAM_W'($urandom_range(NS, 63));
            pick = $urandom_range(0, 99);
            if (pick < 5)       cnt = 16'hFFFF;
            else if (pick < 10) cnt = '0;
            else                cnt = ssrm_pkg::COUNT_W'($urandom_range(0, 16'hFFFF));
            send_meter_request(op, t_item, s, cnt,
                               ssrm_pkg::WLEN_W'($urandom_range(0, 15)));
        end
        steady = 1'b0;
    endtask

    // last: once the ring is stamped with the top second nothing later can advance it
    task automatic test_time_extremes();
        send_meter_request(ssrm_pkg::OP_ADD, 32'hFFFF_FFFF, 5, 16'hFFFF, 4'hF);
        send_meter_request(ssrm_pkg::OP_QUERY, 32'hFFFF_FFFF, 5, 0, 15);
        send_meter_request(ssrm_pkg::OP_ADD, 0, 5, 1, 0);
        send_meter_request(ssrm_pkg::OP_QUERY, 0, 5, 0, 1);
    endtask

    always @(posedge i_clk) begin : result_check
        t_meter_reply got;
        t_meter_reply want;
        if (o_valid && !i_stall) begin
            got = {o_window_sum, o_rate_q8, o_valid_res};
            if (expected_replies.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: sum %0d rate %0h valid %0b",
                             got.window_sum, got.rate_q8, got.valid_res);
            end else begin
                want = expected_replies.pop_front();
                if (got.window_sum !== want.window_sum || got.rate_q8 !== want.rate_q8 ||
                    got.valid_res !== want.valid_res) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("result mismatch: sum %0d/%0d rate %0h/%0h valid %0b/%0b",
                                 want.window_sum, got.window_sum, want.rate_q8, got.rate_q8,
                                 want.valid_res, got.valid_res);
                end
            end
            rx_hold = steady ? 0 : $urandom_range(0, 3);
        end else if (o_valid && rx_hold > 0) begin
            rx_hold--;
        end
        i_stall <= (rx_hold != 0);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        head_bucket = 0;
        for (int b = 0; b < NB; b++) wipe_bucket(b, '0);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_add_and_query();
        test_invalid_stream();
        test_window_lengths();
        test_time_backwards();
        test_stale_walk();
        test_random_traffic();
        test_time_extremes();
        i_valid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
